### src/accel_fall_detector_assert.svh
// Assertion macros shared by the fall detector RTL.
`ifndef ACCEL_FALL_DETECTOR_ASSERT_SVH
`define ACCEL_FALL_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define AFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fall detector assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define AFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fall detector assertion failed");

`endif

### src/afd_pkg.sv
// Shared types and constants for the accelerometer fall detector.
`default_nettype none
package afd_pkg;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  localparam logic [8:0]  AlphaReset   = 9'd77;
  localparam logic [8:0]  AlphaFull    = 9'd256;
  localparam logic [15:0] FfThrReset   = 16'd1024;
  localparam logic [15:0] ImpThrReset  = 16'd6144;
  localparam logic [15:0] FfMinReset   = 16'd200;
  localparam logic [23:0] LevelReset   = 24'd524288;

  // Square-root unit: one result bit per iteration.
  localparam int RootIters = 16;
  localparam logic [3:0] RootLastIter = 4'(RootIters - 1);

  typedef enum logic [CfgIdxW-1:0] {
    REG_EMA_ALPHA = 2'd0,
    REG_FF_THR    = 2'd1,
    REG_IMP_THR   = 2'd2,
    REG_FF_MIN    = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_START,
    ST_ROOT_WAIT,
    ST_EMA,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] smoothed_level;
    logic        falling;
    logic        long_freefall;
    logic        impact_now;
    logic        fall_seen;
  } out_item_t;

  typedef struct packed {
    logic en;
    logic clear;
  } mac_ctrl_t;

endpackage
`default_nettype wire

### src/afd_mac.sv
// Shared multiply-accumulate unit for squares and the moving average.
`default_nettype none
module afd_mac (
  input  wire logic              clk,
  input  wire afd_pkg::mac_ctrl_t ctrl,
  input  wire logic [23:0]       a,
  input  wire logic [15:0]       b,
  output logic [33:0]            acc
);
  import afd_pkg::*;

  logic [33:0] product;
  logic [33:0] acc_next;

  // Every product used here stays below 2^33, so 34 bits hold it.
  assign product = 34'(a) * 34'(b);

  always_comb begin
    if (ctrl.clear) begin
      acc_next = product;
    end else begin
      acc_next = acc + product;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= acc_next;
    end
  end

endmodule
`default_nettype wire

### src/afd_isqrt.sv
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module afd_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] radicand,
  output logic             busy,
  output logic [15:0]      root
);
  import afd_pkg::*;

  logic [31:0] rem;
  logic [31:0] acc_root;
  logic [31:0] bitpos;
  logic [3:0]  iter;
  logic [31:0] trial;
  logic        fits;

  assign trial = acc_root + bitpos;
  assign fits  = rem >= trial;
  assign root  = acc_root[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= 4'd0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= 4'd0;
    end else if (busy) begin
      iter <= iter + 4'd1;
      if (iter == RootLastIter) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= radicand;
      acc_root <= 32'd0;
      bitpos   <= 32'h4000_0000;
    end else if (busy) begin
      if (fits) begin
        rem      <= rem - trial;
        acc_root <= (acc_root >> 1) + bitpos;
      end else begin
        acc_root <= acc_root >> 1;
      end
      bitpos <= bitpos >> 2;
    end
  end

endmodule
`default_nettype wire

### src/accel_fall_detector.sv
// Top level of the accelerometer free-fall and impact detector.
//
// Input channel (in_valid, in_stall, in_data): one word per sample with
// three signed axes at 2048 LSB per g and a millisecond timestamp.
// Output channel (out_valid, out_stall, out_data): one word per sample with
// the smoothed magnitude and the free-fall, long free-fall, impact and
// sticky fall flags. Configuration (cfg_valid, cfg_ready, cfg_index,
// cfg_data) is always ready; the user must write it only between samples,
// which the block does not enforce. Each sample passes from acceptance
// to the next acceptance through three multiply-accumulate steps for the
// sum of squares, one load and sixteen iterations of the square-root unit
// plus a check that it has finished, two multiply-accumulate steps for the
// moving average and an update step that registers the result word.
// in_stall is high while a sample is being processed. A stalled result
// stays in the output register; a new sample is still taken, but its
// update waits until the earlier result word has been taken.
// Synchronous reset restores default registers, a level of one g, and
// clears free-fall, the fall flag and the output valid.
`default_nettype none
module accel_fall_detector (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire afd_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output afd_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [afd_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [afd_pkg::CfgDataW-1:0]    cfg_data
);
  import afd_pkg::*;

  // Configuration registers.
  logic [8:0]  ema_alpha_q8;
  logic [15:0] freefall_threshold;
  logic [15:0] impact_threshold;
  logic [15:0] freefall_min_ms;

  // Detector state.
  logic [23:0] filtered_level;
  logic        freefall_active;
  logic [31:0] freefall_begin_ms;
  logic        fall_latched;

  // Sample held while it is processed.
  logic [15:0] abs_x;
  logic [15:0] abs_y;
  logic [15:0] abs_z;
  logic [31:0] sample_ms;

  state_e      state;
  state_e      state_next;
  logic [1:0]  step;

  mac_ctrl_t   mac_ctrl;
  logic [23:0] mac_a;
  logic [15:0] mac_b;
  logic [33:0] mac_acc;

  logic        sqrt_start;
  logic        sqrt_busy;
  logic [15:0] sqrt_root;

  logic        in_take;
  logic        out_free;
  logic        do_update;

  logic [8:0]  alpha_eff;
  logic [8:0]  alpha_inv;
  logic [23:0] level_new;
  logic        below_ff;
  logic        above_imp;
  logic        long_now;
  logic        impact;
  logic [31:0] elapsed;
  logic [15:0] ux;
  logic [15:0] uy;
  logic [15:0] uz;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign ux = in_data.accel_x;
  assign uy = in_data.accel_y;
  assign uz = in_data.accel_z;

  // Alpha above one is clamped so the level follows the magnitude.
  assign alpha_eff = (ema_alpha_q8 > AlphaFull) ? AlphaFull : ema_alpha_q8;
  assign alpha_inv = AlphaFull - alpha_eff;

  assign level_new = mac_acc[31:8];
  assign below_ff  = level_new < {freefall_threshold, 8'd0};
  assign above_imp = level_new > {impact_threshold, 8'd0};
  assign elapsed   = sample_ms - freefall_begin_ms;
  assign long_now  = below_ff && freefall_active && (elapsed > {16'd0, freefall_min_ms});
  assign impact    = !below_ff && freefall_active && above_imp;

  afd_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (mac_acc)
  );

  afd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (mac_acc[31:0]),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (step == 2'd2) begin
          state_next = ST_ROOT_START;
        end
      end
      ST_ROOT_START: begin
        state_next = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (!sqrt_busy) begin
          state_next = ST_EMA;
        end
      end
      ST_EMA: begin
        if (step == 2'd1) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    mac_ctrl   = '0;
    mac_a      = 24'd0;
    mac_b      = 16'd0;
    sqrt_start = 1'b0;
    do_update  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SQUARE: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.clear = (step == 2'd0);
        case (step)
          2'd0: begin
            mac_a = {8'd0, abs_x};
            mac_b = abs_x;
          end
          2'd1: begin
            mac_a = {8'd0, abs_y};
            mac_b = abs_y;
          end
          default: begin
            mac_a = {8'd0, abs_z};
            mac_b = abs_z;
          end
        endcase
      end
      ST_ROOT_START: begin
        sqrt_start = 1'b1;
      end
      ST_ROOT_WAIT: begin
        in_stall = 1'b1;
      end
      ST_EMA: begin
        mac_ctrl.en = 1'b1;
        if (step == 2'd0) begin
          mac_ctrl.clear = 1'b1;
          mac_a = {sqrt_root, 8'd0};
          mac_b = {7'd0, alpha_eff};
        end else begin
          mac_a = filtered_level;
          mac_b = {7'd0, alpha_inv};
        end
      end
      ST_UPDATE: begin
        do_update = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= 2'd0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        step <= 2'd0;
      end else begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ema_alpha_q8       <= AlphaReset;
      freefall_threshold <= FfThrReset;
      impact_threshold   <= ImpThrReset;
      freefall_min_ms    <= FfMinReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_EMA_ALPHA: ema_alpha_q8       <= cfg_data[8:0];
        REG_FF_THR:    freefall_threshold <= cfg_data;
        REG_IMP_THR:   impact_threshold   <= cfg_data;
        REG_FF_MIN:    freefall_min_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Magnitudes of the axes; the most negative value maps to 32768.
  always_ff @(posedge clk) begin
    if (in_take) begin
      abs_x     <= ux[15] ? 16'(~ux + 16'd1) : ux;
      abs_y     <= uy[15] ? 16'(~uy + 16'd1) : uy;
      abs_z     <= uz[15] ? 16'(~uz + 16'd1) : uz;
      sample_ms <= in_data.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_level    <= LevelReset;
      freefall_active   <= 1'b0;
      freefall_begin_ms <= 32'd0;
      fall_latched      <= 1'b0;
    end else if (do_update) begin
      filtered_level <= level_new;
      if (below_ff) begin
        if (!freefall_active) begin
          freefall_begin_ms <= sample_ms;
        end
        freefall_active <= 1'b1;
      end else begin
        freefall_active <= 1'b0;
        if (impact) begin
          fall_latched <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_update) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      out_data.smoothed_level <= level_new[23:8];
      out_data.falling        <= below_ff;
      out_data.long_freefall  <= long_now;
      out_data.impact_now     <= impact;
      out_data.fall_seen      <= fall_latched || impact;
    end
  end

`include "accel_fall_detector_assert.svh"

  `AFD_ASSERT_NEXT(a_accept_starts_squares, in_valid && !in_stall, state == ST_SQUARE)
  `AFD_ASSERT_NOW(a_root_busy_only_waiting, sqrt_busy, state == ST_ROOT_WAIT)
  `AFD_ASSERT_NOW(a_impact_sets_flag, out_valid && out_data.impact_now, out_data.fall_seen)
  `AFD_ASSERT_NOW(a_long_needs_falling, out_valid && out_data.long_freefall, out_data.falling)

endmodule
`default_nettype wire

### bench/accel_fall_detector_tb.sv
// Self-checking testbench for the accelerometer free-fall and impact detector.
module accel_fall_detector_tb;
  import afd_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_PHASES  = 18;
  localparam int PHASE_ITEMS    = 88;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int PLAN_ROWS      = 35;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  // One directed step: either a register write or a sample, with the result
  // word typed in when has_want is set.
  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    idx;
    int          wdata;
    int          x;
    int          y;
    int          z;
    logic [31:0] stamp;
    bit          has_want;
    int          lvl;
    bit          fall;
    bit          lng;
    bit          hit;
    bit          seen;
  } plan_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // Detector state and register copies kept by the testbench.
  logic [23:0] ema_level;
  logic        ff_running;
  logic [31:0] freefall_t0;
  logic        fall_sticky;
  logic [8:0]  cfg_alpha;
  logic [15:0] cfg_ff_thr;
  logic [15:0] cfg_imp_thr;
  logic [15:0] cfg_ff_min;

  out_item_t   pending_results[$];
  out_item_t   oldest;
  int          mismatches = 0;
  int          items_sent = 0;
  logic [31:0] clock_ms = 32'd0;
  bit          offering = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 2048, 32'd0, 1'b1, 2048, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 0, 32'd10, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_EMA_ALPHA, 256, 0, 0, 0, 32'd0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 0, 32'd100, 1'b1, 0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 0, 32'd300, 1'b1, 0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 0, 32'd301, 1'b1, 0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, -32768, -32768, -32768, 32'd400, 1'b1, 56755,
      1'b0, 1'b0, 1'b1, 1'b1},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 32767, 32767, 32767, 32'd410, 1'b1, 56754,
      1'b0, 1'b0, 1'b0, 1'b1},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, -1, 32'hFFFF_FFF0, 1'b1, 1, 1'b1, 1'b0, 1'b0, 1'b1},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 1, 0, 0, 32'h0000_00D9, 1'b1, 1, 1'b1, 1'b1, 1'b0, 1'b1},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 6144, 0, 0, 32'h100, 1'b1, 6144, 1'b0, 1'b0, 1'b0, 1'b1},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 1024, 0, 0, 32'd500, 1'b1, 1024, 1'b0, 1'b0, 1'b0, 1'b1},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 1023, 0, 0, 32'd600, 1'b1, 1023, 1'b1, 1'b0, 1'b0, 1'b1},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 6145, 0, 32'd610, 1'b1, 6145, 1'b0, 1'b0, 1'b1, 1'b1},
    '{ROW_WRITE, REG_EMA_ALPHA, 0, 0, 0, 0, 32'd0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 32767, -32768, 32767, 32'd700, 1'b1, 6145,
      1'b0, 1'b0, 1'b0, 1'b1},
    '{ROW_WRITE, REG_EMA_ALPHA, 65535, 0, 0, 0, 32'd0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 300, 32'd800, 1'b1, 300, 1'b1, 1'b0, 1'b0, 1'b1},
    '{ROW_WRITE, REG_FF_MIN, 0, 0, 0, 0, 32'd0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 0, 32'd800, 1'b1, 0, 1'b1, 1'b0, 1'b0, 1'b1},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 0, 32'd801, 1'b1, 0, 1'b1, 1'b1, 1'b0, 1'b1},
    '{ROW_WRITE, REG_FF_MIN, 65535, 0, 0, 0, 32'd0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 0, 32'd66335, 1'b1, 0, 1'b1, 1'b0, 1'b0, 1'b1},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 0, 32'd66336, 1'b1, 0, 1'b1, 1'b1, 1'b0, 1'b1},
    '{ROW_WRITE, REG_FF_THR, 0, 0, 0, 0, 32'd0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 0, 32'd66400, 1'b1, 0, 1'b0, 1'b0, 1'b0, 1'b1},
    '{ROW_WRITE, REG_IMP_THR, 0, 0, 0, 0, 32'd0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_FF_THR, 65535, 0, 0, 0, 32'd0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 0, 32'd70000, 1'b1, 0, 1'b1, 1'b0, 1'b0, 1'b1},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 1, 32'd70001, 1'b1, 1, 1'b1, 1'b0, 1'b0, 1'b1},
    '{ROW_WRITE, REG_FF_THR, 1, 0, 0, 0, 32'd0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 0, 0, 1, 32'd70002, 1'b1, 1, 1'b0, 1'b0, 1'b1, 1'b1},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, -300, 400, -1200, 32'd70010, 1'b0, 0,
      1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_EMA_ALPHA, 77, 0, 0, 0, 32'd0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SAMPLE, REG_EMA_ALPHA, 0, 2048, 2048, 2048, 32'd70020, 1'b0, 0,
      1'b0, 1'b0, 1'b0, 1'b0}
  };

  accel_fall_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic [15:0] axis_abs(logic signed [15:0] v);
    logic signed [16:0] w;
    w = v;
    if (w < 0) w = -w;
    return w[15:0];
  endfunction

  function automatic logic [15:0] floor_sqrt(logic [31:0] v);
    logic [15:0] root;
    logic [15:0] trial;
    root = '0;
    for (int i = 15; i >= 0; i--) begin
      trial = root | (16'd1 << i);
      if (32'(trial) * 32'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  // Advances the detector state by one sample and returns its result word.
  function automatic out_item_t detector_step(in_item_t s);
    logic [33:0] sumsq;
    logic [15:0] mag;
    logic [8:0]  a;
    logic [40:0] acc;
    logic        long_ff;
    logic        hit;
    out_item_t   r;
    sumsq = 34'(axis_abs(s.accel_x)) * 34'(axis_abs(s.accel_x))
          + 34'(axis_abs(s.accel_y)) * 34'(axis_abs(s.accel_y))
          + 34'(axis_abs(s.accel_z)) * 34'(axis_abs(s.accel_z));
    mag = floor_sqrt(sumsq[31:0]);
    a = (cfg_alpha > AlphaFull) ? AlphaFull : cfg_alpha;
    acc = 41'(a) * (41'(mag) << 8) + 41'(AlphaFull - a) * 41'(ema_level);
    ema_level = acc[31:8];
    long_ff = 1'b0;
    hit = 1'b0;
    if (ema_level < {cfg_ff_thr, 8'd0}) begin
      if (!ff_running) begin
        ff_running = 1'b1;
        freefall_t0 = s.time_ms;
      end else if (s.time_ms - freefall_t0 > {16'd0, cfg_ff_min}) begin
        long_ff = 1'b1;
      end
    end else begin
      if (ff_running && ema_level > {cfg_imp_thr, 8'd0}) begin
        hit = 1'b1;
        fall_sticky = 1'b1;
      end
      ff_running = 1'b0;
    end
    r.smoothed_level = ema_level[23:8];
    r.falling        = ff_running;
    r.long_freefall  = long_ff;
    r.impact_now     = hit;
    r.fall_seen      = fall_sticky;
    return r;
  endfunction

  function automatic in_item_t shaped_sample(int mag, logic [31:0] stamp);
    in_item_t s;
    int       axis;
    int       lead;
    axis = $urandom_range(2);
    lead = ($urandom_range(1) == 1) ? -mag : mag;
    s.accel_x = 16'((axis == 0) ? lead : int'($urandom_range(0, 400)) - 200);
    s.accel_y = 16'((axis == 1) ? lead : int'($urandom_range(0, 400)) - 200);
    s.accel_z = 16'((axis == 2) ? lead : int'($urandom_range(0, 400)) - 200);
    s.time_ms = stamp;
    return s;
  endfunction

  function automatic logic [15:0] pick_setting(int lo, int hi);
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance with
  // the word still offered, so the caller either offers the next one or idles.
  task automatic send_item(in_item_t s, bit has_want, out_item_t want);
    out_item_t predicted;
    if (!quiet && $urandom_range(99) < 8) begin
      if (offering) in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
    in_data  <= s;
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = detector_step(s);
    pending_results.push_back(has_want ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_shaped(int mag, int step_ms);
    clock_ms += 32'(step_ms);
    send_item(shaped_sample(mag, clock_ms), 1'b0, '0);
  endtask

  task automatic idle_input();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_EMA_ALPHA: cfg_alpha = value[8:0];
      REG_FF_THR:    cfg_ff_thr = value;
      REG_IMP_THR:   cfg_imp_thr = value;
      REG_FF_MIN:    cfg_ff_min = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly a rest, a drop and a hit; sometimes a burst of raw noise.
  task automatic run_episode();
    int       n;
    in_item_t s;
    if ($urandom_range(99) < 80) begin
      n = $urandom_range(1, 8);
      repeat (n) send_shaped($urandom_range(1700, 2400), $urandom_range(5, 20));
      n = $urandom_range(1, 40);
      repeat (n) send_shaped($urandom_range(0, 700), $urandom_range(1, 30));
      n = $urandom_range(1, 5);
      repeat (n) send_shaped($urandom_range(6000, 32767), $urandom_range(1, 10));
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        s.accel_x = 16'($urandom);
        s.accel_y = 16'($urandom);
        s.accel_z = 16'($urandom);
        s.time_ms = $urandom;
        send_item(s, 1'b0, '0);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %p", $time, out_data);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("smoothed_level", int'(oldest.smoothed_level),
                    int'(out_data.smoothed_level));
        check_field("falling", int'(oldest.falling), int'(out_data.falling));
        check_field("long_freefall", int'(oldest.long_freefall),
                    int'(out_data.long_freefall));
        check_field("impact_now", int'(oldest.impact_now), int'(out_data.impact_now));
        check_field("fall_seen", int'(oldest.fall_seen), int'(out_data.fall_seen));
      end
    end
  end

  initial begin
    in_item_t  s;
    out_item_t want;
    int        start;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    ema_level   = LevelReset;
    ff_running  = 1'b0;
    freefall_t0 = '0;
    fall_sticky = 1'b0;
    cfg_alpha   = AlphaReset;
    cfg_ff_thr  = FfThrReset;
    cfg_imp_thr = ImpThrReset;
    cfg_ff_min  = FfMinReset;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        idle_input();
        wait_drained();
        write_reg(plan[i].idx, 16'(plan[i].wdata));
      end else begin
        s.accel_x = 16'(plan[i].x);
        s.accel_y = 16'(plan[i].y);
        s.accel_z = 16'(plan[i].z);
        s.time_ms = plan[i].stamp;
        want.smoothed_level = 16'(plan[i].lvl);
        want.falling        = plan[i].fall;
        want.long_freefall  = plan[i].lng;
        want.impact_now     = plan[i].hit;
        want.fall_seen      = plan[i].seen;
        send_item(s, plan[i].has_want, want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_input();
      wait_drained();
      // A few phases run with neither side idling.
      quiet = (ph >= 6 && ph <= 8);
      case ($urandom_range(9))
        0: write_reg(REG_EMA_ALPHA, 16'd1);
        1: write_reg(REG_EMA_ALPHA, 16'd256);
        2: write_reg(REG_EMA_ALPHA, 16'd0);
        3: write_reg(REG_EMA_ALPHA, 16'($urandom_range(257, 65535)));
        default: write_reg(REG_EMA_ALPHA, 16'($urandom_range(16, 220)));
      endcase
      write_reg(REG_FF_THR, pick_setting(300, 3000));
      write_reg(REG_IMP_THR, pick_setting(2500, 12000));
      write_reg(REG_FF_MIN, pick_setting(0, 400));
      if ($urandom_range(3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      // The receiver holds off while samples keep coming, so the block backs up.
      if (ph == 3) hold_req = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) run_episode();
    end

    idle_input();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
